@@ src/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants, types and codes for the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam int CFG_W      = 5;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int KIND_W     = 2;

  localparam logic [CFG_W-1:0]  MAX_CHARS_RST = 5'd31;

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
  localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ECHO,
    ST_FETCH,
    ST_LINE,
    ST_END
  } state_t;

  typedef enum logic [1:0] {
    ECHO_CHAR,
    ECHO_CRLF,
    ECHO_RUBOUT
  } echo_mode_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              err;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ src/cle_line_ram.sv @@
// ----------------------------------------------------------------------------
// cle_line_ram
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cle_line_ram (
  input  logic                          clk,
  input  cle_pkg::ram_req_t             req,
  output logic [cle_pkg::BYTE_W-1:0]    rdata
);
  import cle_pkg::*;

  logic [BYTE_W-1:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ src/cle_ctrl.sv @@
// ----------------------------------------------------------------------------
// cle_ctrl
// Sequencer: classifies each received byte, keeps the count, walks the echo
// sequence and then the stored line and its end marker, one result beat per free output slot.
// ----------------------------------------------------------------------------
module cle_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cle_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          rx_error,
  input  logic [cle_pkg::CFG_W-1:0]     max_chars,
  input  logic                          slot_free,
  output logic                          load,
  output cle_pkg::result_t              res,
  output cle_pkg::ram_req_t             ram_req,
  input  logic [cle_pkg::BYTE_W-1:0]    ram_rdata
);
  import cle_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic [BYTE_W-1:0] in_byte;
  echo_mode_t        echo_mode;
  logic [1:0]        echo_i;
  logic              line_pend;
  logic [CNT_W-1:0]  len;
  logic              err;
  logic [ADDR_W-1:0] idx;

  logic              accept;
  logic              is_term, is_bs;
  logic              store_ok, hit;
  logic [CNT_W-1:0]  count_new, lim;
  logic [BYTE_W-1:0] echo_byte;
  logic [1:0]        echo_top;
  logic              echo_done;
  logic [CNT_W-1:0]  idx_inc;
  logic              more;

  // no beat is taken while in reset
  assign accept   = (state == ST_IDLE) && in_valid && !rst;
  assign in_stall = rst || (state != ST_IDLE);

  assign is_term = rx_error || (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign is_bs   = (rx_byte == CH_BS);

  // effective limit: zero acts as one, never beyond the store
  always_comb begin
    lim = (max_chars == '0) ? CNT_W'(1) : CNT_W'(max_chars);
    if (lim > CNT_W'(LINE_DEPTH)) begin
      lim = CNT_W'(LINE_DEPTH);
    end
  end

  assign store_ok  = (count < CNT_W'(LINE_DEPTH));
  assign count_new = store_ok ? count + CNT_W'(1) : count;
  assign hit       = (count_new >= lim);

  always_comb begin
    unique case (echo_mode)
      ECHO_CHAR: begin
        echo_byte = in_byte;
        echo_top  = 2'd0;
      end
      ECHO_CRLF: begin
        echo_byte = (echo_i == 2'd0) ? CH_CR : CH_LF;
        echo_top  = 2'd1;
      end
      ECHO_RUBOUT: begin
        echo_byte = (echo_i == 2'd1) ? CH_SP : CH_BS;
        echo_top  = 2'd2;
      end
      default: begin
        echo_byte = in_byte;
        echo_top  = 2'd0;
      end
    endcase
  end

  assign echo_done = (echo_i == echo_top);
  assign idx_inc   = CNT_W'(idx) + CNT_W'(1);
  assign more      = (idx_inc < len);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !(is_bs && !is_term && count == '0)) begin
          state_next = ST_ECHO;
        end
      end
      ST_ECHO: begin
        if (slot_free && echo_done) begin
          if (!line_pend) begin
            state_next = ST_IDLE;
          end else if (len != '0) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_END;
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_LINE;
      end
      ST_LINE: begin
        if (slot_free && !more) begin
          state_next = ST_END;
        end
      end
      ST_END: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    load          = 1'b0;
    res.kind      = KIND_ECHO;
    res.data      = '0;
    res.len       = '0;
    res.err       = 1'b0;
    res.last      = 1'b0;
    ram_req.we    = accept && !is_term && !is_bs && store_ok;
    ram_req.waddr = count[ADDR_W-1:0];
    ram_req.wdata = rx_byte;
    ram_req.re    = 1'b0;
    ram_req.raddr = idx;
    unique case (state)
      ST_IDLE: begin
      end
      ST_ECHO: begin
        load     = slot_free;
        res.data = echo_byte;
        res.last = echo_done && !line_pend;
      end
      ST_FETCH: begin
        ram_req.re = 1'b1;
      end
      ST_LINE: begin
        load          = slot_free;
        res.kind      = KIND_LINE;
        res.data      = ram_rdata;
        ram_req.re    = slot_free && more;
        ram_req.raddr = idx_inc[ADDR_W-1:0];
      end
      ST_END: begin
        load     = slot_free;
        res.kind = KIND_END;
        res.len  = len[LEN_W-1:0];
        res.err  = err;
        res.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      echo_i    <= '0;
      line_pend <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        in_byte <= rx_byte;
        echo_i  <= '0;
        idx     <= '0;
        if (is_term) begin
          echo_mode <= ECHO_CRLF;
          line_pend <= 1'b1;
          len       <= count;
          err       <= rx_error;
          count     <= '0;
        end else if (is_bs) begin
          echo_mode <= ECHO_RUBOUT;
          line_pend <= 1'b0;
          if (count != '0) begin
            count <= count - CNT_W'(1);
          end
        end else begin
          echo_mode <= ECHO_CHAR;
          line_pend <= hit;
          len       <= count_new;
          err       <= 1'b0;
          count     <= hit ? '0 : count_new;
        end
      end
      if (state == ST_ECHO && slot_free && !echo_done) begin
        echo_i <= echo_i + 2'd1;
      end
      if (state == ST_LINE && slot_free && more) begin
        idx <= idx_inc[ADDR_W-1:0];
      end
    end
  end

endmodule

@@ src/console_line_editor.sv @@
// ----------------------------------------------------------------------------
// console_line_editor
// Builds a command line from received console bytes, with echo.
// ----------------------------------------------------------------------------
// One received byte is taken per beat while the editor is idle; in_stall then
// stays high until every result beat that byte causes has been loaded into
// the output register. An ordinary byte is echoed as one beat, CR/LF or a
// receive error as two (CR, LF) and a backspace as three (BS, space, BS);
// a backspace on an empty line gives nothing. When a line with stored bytes
// ends, a fetch state primes the single read port of the line store, then
// each stored byte goes out as a beat, followed by the end marker; a line
// ended by CR holds at most 30 bytes and a line that fills up at most 31,
// and out_stall can hold any beat. A new byte can be taken while the final
// result of the previous one still waits in the output register. max_chars
// (reset 31) may only be written while idle; zero acts as one.
// ----------------------------------------------------------------------------
module console_line_editor (
  input  logic                          clk,
  input  logic                          rst,
  // received byte channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cle_pkg::BYTE_W-1:0]    rx_byte,
  input  logic                          rx_error,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cle_pkg::KIND_W-1:0]    kind,
  output logic [cle_pkg::BYTE_W-1:0]    data_byte,
  output logic [cle_pkg::LEN_W-1:0]     line_length,
  output logic                          line_error,
  output logic                          last,
  // max_chars register write
  input  logic                          cfg_write,
  input  logic [cle_pkg::CFG_W-1:0]     cfg_data
);
  import cle_pkg::*;

  logic [CFG_W-1:0]  max_chars;
  logic              slot_free;
  logic              load;
  result_t           res;
  result_t           out_res;
  ram_req_t          ram_req;
  logic [BYTE_W-1:0] ram_rdata;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= MAX_CHARS_RST;
    end else if (cfg_write) begin
      max_chars <= cfg_data;
    end
  end

  // output register: loaded only when empty or being taken, so a stalled
  // beat holds still
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  assign kind        = out_res.kind;
  assign data_byte   = out_res.data;
  assign line_length = out_res.len;
  assign line_error  = out_res.err;
  assign last        = out_res.last;

  cle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .rx_error  (rx_error),
    .max_chars (max_chars),
    .slot_free (slot_free),
    .load      (load),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  cle_line_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule
